@@ design/sft_pkg.sv @@
// Shared types and constants for the sequence frontier tracker.
package sft_pkg;

   localparam int NUM_SOURCES = 16;
   localparam int WINDOW      = 64;
   localparam int SEQ_W       = 32;
   localparam int SOURCE_W    = 4;
   localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int WIN_IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int RUN_W       = $clog2(WINDOW + 1);

   typedef enum logic {
      CMD_OBSERVE = 1'b0,
      CMD_TRUST   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [SOURCE_W-1:0] source;
      logic [SEQ_W-1:0]    seq;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0] frontier_out;
      logic             advanced;
      logic             stale;
      logic             overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_ADV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic adv;
   } dp_cmd_type;

endpackage

@@ design/sequence_frontier_tracker.sv @@
// Sequence frontier tracker top level: controller, datapath and checks.
//
// One word is handled at a time. After acceptance it passes through a table
// read with mark or trust update, then a trailing-ones advance with
// write-back; the result word is registered and held until taken. The next word
// is accepted in the cycle after the result is taken. Per-source state is in
// flip-flops cleared by reset; no warm-up is needed after reset.
module sequence_frontier_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sft_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sft_pkg::rsp_type rsp_word
);

   sft_pkg::dp_cmd_type dp_cmd;

   sft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   sft_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .dp_cmd   (dp_cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready && !rsp_valid)
      else $error("controller did not go busy after accept");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.stale && rsp_word.overflow))
      else $error("stale and overflow both set");

   a_no_adv_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.stale || rsp_word.overflow)) |-> !rsp_word.advanced)
      else $error("frontier advanced on dropped word");

endmodule

@@ design/sft_ctrl.sv @@
// Controller: sequences one word through load, update and advance steps.
module sft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sft_pkg::dp_cmd_type dp_cmd
);

   sft_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sft_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.calc = 1'b0;
      dp_cmd.adv  = 1'b0;
      case (state_ff)
         sft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = sft_pkg::ST_CALC;
            end
         end
         sft_pkg::ST_CALC: begin
            dp_cmd.calc = 1'b1;
            state_in    = sft_pkg::ST_ADV;
         end
         sft_pkg::ST_ADV: begin
            dp_cmd.adv = 1'b1;
            state_in   = sft_pkg::ST_DONE;
         end
         sft_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sft_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/sft_dp.sv @@
// Datapath: per-source frontier and pending bitmap tables, update and run advance.
module sft_dp (
   input  logic                clock,
   input  logic                reset,
   input  sft_pkg::dp_cmd_type dp_cmd,
   input  sft_pkg::req_type    req_word,
   output sft_pkg::rsp_type    rsp_word
);

   localparam logic [sft_pkg::SOURCE_W:0] SRC_LIMIT =
      sft_pkg::NUM_SOURCES[sft_pkg::SOURCE_W:0];
   localparam logic [sft_pkg::SEQ_W:0] WIN_LIMIT = (sft_pkg::SEQ_W + 1)'(sft_pkg::WINDOW);

   logic [sft_pkg::SEQ_W-1:0]  frontier_ff [sft_pkg::NUM_SOURCES];
   logic [sft_pkg::WINDOW-1:0] bitmap_ff   [sft_pkg::NUM_SOURCES];

   sft_pkg::req_type           req_ff;
   logic [sft_pkg::SEQ_W-1:0]  before_ff;
   logic [sft_pkg::SEQ_W-1:0]  f1_ff, f1_in;
   logic [sft_pkg::WINDOW-1:0] m1_ff, m1_in;
   logic                       stale_ff, stale_in;
   logic                       ovf_ff, ovf_in;
   sft_pkg::rsp_type           rsp_ff, rsp_in;

   logic [sft_pkg::SRC_IDX_W-1:0] idx;
   logic                          src_ok;
   logic [sft_pkg::SEQ_W-1:0]     cur_f;
   logic [sft_pkg::WINDOW-1:0]    cur_m;
   logic [sft_pkg::SEQ_W:0]       diff;
   logic [sft_pkg::SEQ_W:0]       offset;
   logic                          above;

   logic [sft_pkg::RUN_W-1:0]     run;
   logic [sft_pkg::WINDOW-1:0]    m2;
   logic [sft_pkg::SEQ_W:0]       sum;
   logic [sft_pkg::SEQ_W-1:0]     f2;

   assign idx    = req_ff.source[sft_pkg::SRC_IDX_W-1:0];
   assign src_ok = {1'b0, req_ff.source} < SRC_LIMIT;
   assign cur_f  = frontier_ff[idx];
   assign cur_m  = bitmap_ff[idx];

   // Step one: mark or trust.
   always_comb begin
      diff     = {1'b0, req_ff.seq} - {1'b0, cur_f};
      offset   = diff - {{sft_pkg::SEQ_W{1'b0}}, 1'b1};
      above    = req_ff.seq > cur_f;
      f1_in    = cur_f;
      m1_in    = cur_m;
      stale_in = 1'b0;
      ovf_in   = 1'b0;
      if (req_ff.cmd == sft_pkg::CMD_OBSERVE) begin
         if (req_ff.seq == '0 || !above) begin
            stale_in = 1'b1;
         end else if (offset >= WIN_LIMIT) begin
            ovf_in = 1'b1;
         end else begin
            m1_in = cur_m | (sft_pkg::WINDOW'(1) << offset[sft_pkg::WIN_IDX_W-1:0]);
         end
      end else if (req_ff.seq != '0 && above) begin
         f1_in = req_ff.seq;
         if (diff >= WIN_LIMIT) begin
            m1_in = '0;
         end else begin
            m1_in = cur_m >> diff[sft_pkg::WIN_IDX_W-1:0];
         end
      end
   end

   // Step two: trailing-ones run, shift and saturating frontier add.
   always_comb begin
      run = sft_pkg::RUN_W'(sft_pkg::WINDOW);
      for (int i = sft_pkg::WINDOW - 1; i >= 0; i--) begin
         if (!m1_ff[i]) begin
            run = sft_pkg::RUN_W'(i);
         end
      end
      if (run == sft_pkg::RUN_W'(sft_pkg::WINDOW)) begin
         m2 = '0;
      end else begin
         m2 = m1_ff >> run;
      end
      sum = {1'b0, f1_ff} + {{(sft_pkg::SEQ_W + 1 - sft_pkg::RUN_W){1'b0}}, run};
      f2  = sum[sft_pkg::SEQ_W] ? {sft_pkg::SEQ_W{1'b1}} : sum[sft_pkg::SEQ_W-1:0];
      rsp_in = '0;
      if (src_ok) begin
         rsp_in.frontier_out = f2;
         rsp_in.advanced     = f2 != before_ff;
         rsp_in.stale        = stale_ff;
         rsp_in.overflow     = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         req_ff <= req_word;
      end
      if (dp_cmd.calc) begin
         before_ff <= cur_f;
         f1_ff     <= f1_in;
         m1_ff     <= m1_in;
         stale_ff  <= stale_in;
         ovf_ff    <= ovf_in;
      end
      if (dp_cmd.adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sft_pkg::NUM_SOURCES; i++) begin
            frontier_ff[i] <= '0;
            bitmap_ff[i]   <= '0;
         end
      end else if (dp_cmd.adv && src_ok) begin
         frontier_ff[idx] <= f2;
         bitmap_ff[idx]   <= m2;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

@@ test/sft_checker.sv @@
// Checker for the sequence frontier tracker: predicts each result word and compares it.
module sft_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sft_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sft_pkg::rsp_type rsp_word,
   output int               mismatches,
   output int               outstanding,
   output int               words_checked,
   output int               advances,
   output int               stales,
   output int               overflows
);
   import sft_pkg::*;

   logic [SEQ_W-1:0]  frontier [NUM_SOURCES];
   logic [WINDOW-1:0] marks    [NUM_SOURCES];
   rsp_type           expected_frontiers [$];
   int                bad_count;
   int                checked_count;
   int                adv_count;
   int                stale_count;
   int                ovf_count;

   function automatic rsp_type apply_sequence_event(input req_type w);
      rsp_type           r;
      logic [SEQ_W-1:0]  was;
      logic [SEQ_W-1:0]  f;
      logic [SEQ_W-1:0]  offset;
      logic [WINDOW-1:0] m;
      logic              walk;
      int                run;
      r = '0;
      if (w.source >= NUM_SOURCES) return r;
      was  = frontier[w.source];
      f    = was;
      m    = marks[w.source];
      walk = 1'b0;
      if (w.cmd == CMD_OBSERVE) begin
         if (w.seq == '0 || w.seq <= f) begin
            r.stale = 1'b1;
         end else begin
            offset = w.seq - f - 1;
            if (offset >= WINDOW) begin
               r.overflow = 1'b1;
            end else begin
               m[offset[WIN_IDX_W-1:0]] = 1'b1;
               walk = 1'b1;
            end
         end
      end else if (w.seq != '0) begin
         if (w.seq > f) begin
            offset = w.seq - f;
            m = (offset >= WINDOW) ? '0 : (m >> offset);
            f = w.seq;
         end
         walk = 1'b1;
      end
      if (walk) begin
         run = 0;
         while (run < WINDOW && m[run]) run++;
         m = (run >= WINDOW) ? '0 : (m >> run);
         // frontier saturates at the largest sequence number
         if (run > ~f) f = '1;
         else f = f + run;
      end
      frontier[w.source] = f;
      marks[w.source]    = m;
      r.frontier_out = f;
      r.advanced     = (f != was);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            frontier[i] = '0;
            marks[i]    = '0;
         end
         expected_frontiers.delete();
         bad_count     = 0;
         checked_count = 0;
         adv_count     = 0;
         stale_count   = 0;
         ovf_count     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frontiers.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("sft_checker: unexpected word frontier %h adv %b stale %b ovf %b",
                           rsp_word.frontier_out, rsp_word.advanced, rsp_word.stale,
                           rsp_word.overflow);
            end else begin
               exp_word = expected_frontiers.pop_front();
               checked_count++;
               if (exp_word.advanced) adv_count++;
               if (exp_word.stale) stale_count++;
               if (exp_word.overflow) ovf_count++;
               if (rsp_word.frontier_out !== exp_word.frontier_out ||
                   rsp_word.advanced !== exp_word.advanced ||
                   rsp_word.stale !== exp_word.stale ||
                   rsp_word.overflow !== exp_word.overflow) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"sft_checker: mismatch (exp/act) frontier %h/%h adv %b/%b",
                               " stale %b/%b ovf %b/%b"},
                              exp_word.frontier_out, rsp_word.frontier_out,
                              exp_word.advanced, rsp_word.advanced,
                              exp_word.stale, rsp_word.stale,
                              exp_word.overflow, rsp_word.overflow);
               end
            end
         end
         if (req_valid && req_ready) begin
            exp_word           = apply_sequence_event(req_word);
            expected_frontiers = {expected_frontiers, exp_word};
         end
      end
      mismatches    <= bad_count;
      outstanding   <= expected_frontiers.size();
      words_checked <= checked_count;
      advances      <= adv_count;
      stales        <= stale_count;
      overflows     <= ovf_count;
   end

endmodule

@@ test/tb.sv @@
// Testbench top for the sequence frontier tracker: stimulus, handshake idling and verdict.
module tb;
   import sft_pkg::*;

   localparam int ITEMS        = 455;
   localparam int QUIET_TAIL   = 60;
   localparam int PRESSURE_AT  = 200;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 100000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   int mismatches;
   int outstanding;
   int words_checked;
   int advances;
   int stales;
   int overflows;
   int sent        = 0;
   int cycle_count = 0;
   bit quiet       = 1'b0;
   bit held        = 1'b0;

   logic [SEQ_W-1:0] cursor [NUM_SOURCES];

   sequence_frontier_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   sft_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked),
      .advances      (advances),
      .stales        (stales),
      .overflows     (overflows)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic offer(input cmd_type c, input logic [SOURCE_W-1:0] src,
                        input logic [SEQ_W-1:0] q);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= {c, src, q};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
   endtask

   // result side: random stalls, one long hold-off mid-run
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && !held && sent >= PRESSURE_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [SOURCE_W-1:0] s;
      logic [SEQ_W-1:0]    q;
      int                  pick;
      for (int i = 0; i < NUM_SOURCES; i++) cursor[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: stale, gaps, window edge, trust cases, top of range
      offer(CMD_OBSERVE, 4'd0, 32'd0);
      offer(CMD_OBSERVE, 4'd0, 32'd3);
      offer(CMD_OBSERVE, 4'd0, 32'd2);
      offer(CMD_OBSERVE, 4'd0, 32'd1);
      offer(CMD_OBSERVE, 4'd0, 32'd2);
      offer(CMD_OBSERVE, 4'd0, 32'd67);
      offer(CMD_OBSERVE, 4'd0, 32'd68);
      offer(CMD_TRUST,   4'd0, 32'd0);
      offer(CMD_TRUST,   4'd0, 32'd2);
      offer(CMD_TRUST,   4'd0, 32'd66);
      offer(CMD_OBSERVE, 4'd1, 32'd5);
      offer(CMD_OBSERVE, 4'd1, 32'd9);
      offer(CMD_TRUST,   4'd1, 32'd200);
      offer(CMD_OBSERVE, 4'd1, 32'hFFFF_FFFF);
      offer(CMD_TRUST,   4'd2, 32'hFFFF_FFFE);
      offer(CMD_OBSERVE, 4'd2, 32'hFFFF_FFFF);
      offer(CMD_OBSERVE, 4'd2, 32'hFFFF_FFFF);
      offer(CMD_TRUST,   4'd2, 32'hFFFF_FFFF);
      offer(CMD_TRUST,   4'd3, 32'hFFFF_FFC0);
      offer(CMD_OBSERVE, 4'd3, 32'hFFFF_FFFF);
      offer(CMD_OBSERVE, 4'd3, 32'hFFFF_FFC2);
      offer(CMD_TRUST,   4'd3, 32'hFFFF_FFC1);
      offer(CMD_OBSERVE, 4'd15, 32'd1);
      offer(CMD_OBSERVE, 4'd15, 32'd64);
      offer(CMD_TRUST,   4'd15, 32'd63);
      cursor[0]  = 32'd67;
      cursor[1]  = 32'd200;
      cursor[2]  = 32'hFFFF_FFFF;
      cursor[3]  = 32'hFFFF_FFC2;
      cursor[15] = 32'd64;

      // random: mostly near-frontier traffic on a few sources
      while (sent < ITEMS) begin
         s    = ($urandom_range(0, 9) < 7) ? SOURCE_W'($urandom_range(0, 3)) :
                                            SOURCE_W'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            offer(CMD_OBSERVE, s, cursor[s] + $urandom_range(1, 24));
            if ($urandom_range(0, 2) == 0) cursor[s] = cursor[s] + $urandom_range(1, 8);
         end else if (pick < 70) begin
            offer(CMD_OBSERVE, s, cursor[s] + $urandom_range(60, 70));
         end else if (pick < 80) begin
            q = cursor[s] + $urandom_range(0, 80);
            offer(CMD_TRUST, s, q);
            if (q > cursor[s]) cursor[s] = q;
         end else if (pick < 85) begin
            offer(CMD_OBSERVE, s, $urandom);
         end else if (pick < 89) begin
            q = $urandom;
            offer(CMD_TRUST, s, q);
            cursor[s] = q;
         end else if (pick < 91) begin
            q = 32'hFFFF_FFFF - $urandom_range(0, 40);
            offer(CMD_TRUST, s, q);
            cursor[s] = q;
         end else if (pick < 96) begin
            offer(CMD_OBSERVE, s, ($urandom_range(0, 3) == 0) ? '0 :
                                  cursor[s] - $urandom_range(0, 5));
         end else begin
            offer(CMD_TRUST, s, ($urandom_range(0, 1) == 0) ? '0 : cursor[s] - 1);
         end
      end
      req_valid <= 1'b0;

      while (outstanding != 0 || words_checked != sent) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb: %0d words sent, %0d results checked (%0d advanced, %0d stale, %0d overflow)",
               sent, words_checked, advances, stales, overflows);
      $display("tb: random source mix with bursty idling and a %0d-cycle result hold-off",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/sft_pkg.sv
design/sft_ctrl.sv
design/sft_dp.sv
design/sequence_frontier_tracker.sv
test/sft_checker.sv
test/tb.sv
